// ----- rtl/wcns_pkg.sv -----
// ------------------------------------------------------------------------------------------
// wcns_pkg - shared types, constants and grid tables
// Payload structs, controller/datapath command and status, codeword level tables.
// ------------------------------------------------------------------------------------------
`default_nettype none

package wcns_pkg;

   localparam int unsigned VALUE_WIDTH  = 16;
   localparam int unsigned GRID_WIDTH   = 16;
   localparam int unsigned WEIGHT_WIDTH = 16;
   localparam int unsigned DIFF_WIDTH   =
      ((VALUE_WIDTH > GRID_WIDTH) ? VALUE_WIDTH : GRID_WIDTH) + 1;
   localparam int unsigned SQ_WIDTH     = 2 * DIFF_WIDTH;
   localparam int unsigned PROD_WIDTH   = SQ_WIDTH + WEIGHT_WIDTH;
   localparam int unsigned INDEX_WIDTH  = 8;
   localparam int unsigned LEN_WIDTH    = 4;
   localparam int unsigned ADDR_WIDTH   = 3;
   localparam int unsigned MODE_WIDTH   = 2;
   localparam int unsigned TABLE_ENTRIES = 16;

   localparam logic [MODE_WIDTH-1:0] GRID_TERNARY = 2'd0;
   localparam logic [MODE_WIDTH-1:0] GRID_OCTAL   = 2'd1;
   localparam logic [MODE_WIDTH-1:0] GRID_TABLE   = 2'd2;

   // Q8.8 one, used in place of a zero weight
   localparam logic [WEIGHT_WIDTH-1:0] WEIGHT_ONE = 16'd256;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_DRAIN,
      ST_HOLD
   } state_type;

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0]  sample_value;
      logic        [WEIGHT_WIDTH-1:0] importance_weight;
      logic                           end_of_block;
   } req_payload_type;

   typedef struct packed {
      logic [INDEX_WIDTH-1:0] codeword_index;
      logic                   group_error;
   } rsp_payload_type;

   typedef struct packed {
      logic                   store;
      logic [ADDR_WIDTH-1:0]  wr_addr;
      logic                   start;
      logic                   issue;
      logic [INDEX_WIDTH-1:0] entry;
      logic [MODE_WIDTH-1:0]  grid_mode;
      logic [LEN_WIDTH-1:0]   group_len;
      logic                   load_rsp;
      logic                   rsp_err;
   } cmd_type;

   typedef struct packed {
      logic pipe_empty;
   } stat_type;

   function automatic logic [LEN_WIDTH-1:0] group_len(input logic [MODE_WIDTH-1:0] mode,
                                                      input int unsigned max_dims);
      logic [LEN_WIDTH-1:0] n;
      case (mode)
         GRID_TERNARY: n = 4'd8;
         GRID_OCTAL:   n = 4'd4;
         default:      n = 4'd1;
      endcase
      if (32'(n) > max_dims) n = LEN_WIDTH'(max_dims);
      return n;
   endfunction

   function automatic logic signed [GRID_WIDTH-1:0] ternary_level(input logic [1:0] digit);
      logic signed [GRID_WIDTH-1:0] v;
      case (digit)
         2'd0:    v = -16'sd128;
         2'd1:    v = 16'sd0;
         default: v = 16'sd128;
      endcase
      return v;
   endfunction

   function automatic logic signed [GRID_WIDTH-1:0] octal_level(input logic [2:0] digit);
      logic signed [GRID_WIDTH-1:0] v;
      case (digit)
         3'd0:    v = -16'sd256;
         3'd1:    v = -16'sd183;
         3'd2:    v = -16'sd110;
         3'd3:    v = -16'sd37;
         3'd4:    v = 16'sd37;
         3'd5:    v = 16'sd110;
         3'd6:    v = 16'sd183;
         default: v = 16'sd256;
      endcase
      return v;
   endfunction

   function automatic logic signed [GRID_WIDTH-1:0] table_level(input logic [3:0] idx);
      logic signed [GRID_WIDTH-1:0] v;
      case (idx)
         4'd0:    v = -16'sd32512;
         4'd1:    v = -16'sd26624;
         4'd2:    v = -16'sd21248;
         4'd3:    v = -16'sd16640;
         4'd4:    v = -16'sd12544;
         4'd5:    v = -16'sd8960;
         4'd6:    v = -16'sd5632;
         4'd7:    v = -16'sd2560;
         4'd8:    v = 16'sd256;
         4'd9:    v = 16'sd3328;
         4'd10:   v = 16'sd6400;
         4'd11:   v = 16'sd9728;
         4'd12:   v = 16'sd13568;
         4'd13:   v = 16'sd17664;
         4'd14:   v = 16'sd22784;
         default: v = 16'sd28928;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/wcns_ctrl.sv -----
// ------------------------------------------------------------------------------------------
// wcns_ctrl - search controller
// Group fill count, grid mode register, entry sequencing and result hand-off.
// ------------------------------------------------------------------------------------------
`default_nettype none

module wcns_ctrl #(
   parameter int unsigned MAX_DIMS     = 8,
   parameter int unsigned GRID_ENTRIES = 256
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output      logic                            req_ready,
   input  wire logic                            req_end,
   input  wire logic                            csr_valid,
   output      logic                            csr_ready,
   input  wire logic [wcns_pkg::MODE_WIDTH-1:0] csr_wdata,
   output      logic                            rsp_valid,
   input  wire logic                            rsp_ready,
   output      wcns_pkg::cmd_type               cmd,
   input  wire wcns_pkg::stat_type              stat
);

   wcns_pkg::state_type state_ff, state_in;

   logic [wcns_pkg::MODE_WIDTH-1:0]  mode_ff, mode_in;
   logic [wcns_pkg::ADDR_WIDTH-1:0]  fill_ff, fill_in;
   logic [wcns_pkg::INDEX_WIDTH-1:0] entry_ff, entry_in;
   logic                             err_ff, err_in;
   logic                             rsp_valid_ff, rsp_valid_in;

   logic                             req_fire;
   logic                             csr_fire;
   logic                             slot_free;
   logic                             complete;
   logic [wcns_pkg::LEN_WIDTH-1:0]   glen;
   logic [wcns_pkg::ADDR_WIDTH-1:0]  pos;
   logic [wcns_pkg::LEN_WIDTH-1:0]   pos_next;
   logic [wcns_pkg::INDEX_WIDTH-1:0] last_entry;

   assign req_fire  = req_valid & req_ready;
   assign csr_fire  = csr_valid & csr_ready;
   assign slot_free = ~rsp_valid_ff | rsp_ready;
   assign glen      = wcns_pkg::group_len(mode_ff, MAX_DIMS);
   assign pos       = ({1'b0, fill_ff} >= glen) ? '0 : fill_ff;
   assign pos_next  = {1'b0, pos} + 4'd1;
   assign complete  = (pos_next >= glen);
   assign last_entry = (mode_ff == wcns_pkg::GRID_TERNARY || mode_ff == wcns_pkg::GRID_OCTAL)
                       ? wcns_pkg::INDEX_WIDTH'(GRID_ENTRIES - 1)
                       : wcns_pkg::INDEX_WIDTH'(wcns_pkg::TABLE_ENTRIES - 1);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         wcns_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (complete) state_in = wcns_pkg::ST_SEARCH;
               else if (req_end) state_in = wcns_pkg::ST_HOLD;
            end
         end
         wcns_pkg::ST_SEARCH: begin
            if (entry_ff == last_entry) state_in = wcns_pkg::ST_DRAIN;
         end
         wcns_pkg::ST_DRAIN: begin
            if (stat.pipe_empty) state_in = wcns_pkg::ST_HOLD;
         end
         wcns_pkg::ST_HOLD: begin
            if (slot_free) state_in = wcns_pkg::ST_IDLE;
         end
         default: state_in = wcns_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd           = '0;
      cmd.wr_addr   = pos;
      cmd.entry     = entry_ff;
      cmd.grid_mode = mode_ff;
      cmd.group_len = glen;
      cmd.rsp_err   = err_ff;
      req_ready     = 1'b0;
      csr_ready     = 1'b0;
      mode_in       = mode_ff;
      fill_in       = fill_ff;
      entry_in      = entry_ff;
      err_in        = err_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      case (state_ff)
         wcns_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            csr_ready = 1'b1;
            if (req_fire) begin
               cmd.store = 1'b1;
               if (complete) begin
                  cmd.start = 1'b1;
                  entry_in  = '0;
                  err_in    = 1'b0;
                  fill_in   = '0;
               end else if (req_end) begin
                  // block ended inside a group: drop it, report an error
                  err_in  = 1'b1;
                  fill_in = '0;
               end else begin
                  fill_in = pos_next[wcns_pkg::ADDR_WIDTH-1:0];
               end
            end
            if (csr_fire) begin
               mode_in = csr_wdata;
               fill_in = '0;
            end
         end
         wcns_pkg::ST_SEARCH: begin
            cmd.issue = 1'b1;
            entry_in  = entry_ff + 1'b1;
         end
         wcns_pkg::ST_DRAIN: begin
         end
         wcns_pkg::ST_HOLD: begin
            if (slot_free) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wcns_pkg::ST_IDLE;
         mode_ff      <= wcns_pkg::GRID_TERNARY;
         fill_ff      <= '0;
         entry_ff     <= '0;
         err_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         fill_ff      <= fill_in;
         entry_ff     <= entry_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/wcns_dp.sv -----
// ------------------------------------------------------------------------------------------
// wcns_dp - distance datapath
// Group store, codeword generation, per-lane weighted squares, registered sum tree
// and running minimum.
// ------------------------------------------------------------------------------------------
`default_nettype none

module wcns_dp #(
   parameter int unsigned MAX_DIMS = 8
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire wcns_pkg::cmd_type         cmd,
   output      wcns_pkg::stat_type        stat,
   input  wire wcns_pkg::req_payload_type req_payload,
   output      wcns_pkg::rsp_payload_type rsp_payload
);

   localparam int unsigned AW        = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int unsigned LEVELS    = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 0;
   localparam int unsigned LANES_P   = 1 << LEVELS;
   localparam int unsigned SUM_WIDTH = wcns_pkg::PROD_WIDTH + LEVELS;
   localparam int unsigned LAST      = LEVELS + 2;
   localparam int unsigned OCT_SPAN  = 12;

   logic signed [wcns_pkg::VALUE_WIDTH-1:0] sample_store_ff [0:MAX_DIMS-1];
   logic [wcns_pkg::WEIGHT_WIDTH-1:0]       weight_store_ff [0:MAX_DIMS-1];

   logic [1:0]                       tern_ff [0:MAX_DIMS-1];
   logic [1:0]                       tern_in [0:MAX_DIMS-1];
   logic                             carry;
   logic [OCT_SPAN-1:0]              entry_wide;

   logic [wcns_pkg::DIFF_WIDTH-1:0]  mag_ff [0:MAX_DIMS-1];
   logic [wcns_pkg::SQ_WIDTH-1:0]    sq_ff  [0:MAX_DIMS-1];
   logic [SUM_WIDTH-1:0]             tree_ff [0:LEVELS][0:LANES_P-1];

   logic [LAST:0]                    v_ff;
   logic [wcns_pkg::INDEX_WIDTH-1:0] idx_ff [0:LAST];

   logic                             first_ff;
   logic [SUM_WIDTH-1:0]             best_sum_ff;
   logic [wcns_pkg::INDEX_WIDTH-1:0] best_idx_ff;
   logic [SUM_WIDTH-1:0]             total;
   logic                             take;

   wcns_pkg::rsp_payload_type        rsp_ff;

   // group store; a zero weight is kept as one
   always_ff @(posedge clock) begin
      if (cmd.store) begin
         sample_store_ff[cmd.wr_addr[AW-1:0]] <= req_payload.sample_value;
         weight_store_ff[cmd.wr_addr[AW-1:0]] <=
            (req_payload.importance_weight == '0) ? wcns_pkg::WEIGHT_ONE
                                                  : req_payload.importance_weight;
      end
   end

   // base-3 digit counter, least significant digit in lane 0
   always_comb begin
      carry = 1'b1;
      for (int d = 0; d < MAX_DIMS; d++) begin
         if (carry) begin
            if (tern_ff[d] == 2'd2) begin
               tern_in[d] = 2'd0;
            end else begin
               tern_in[d] = tern_ff[d] + 2'd1;
               carry      = 1'b0;
            end
         end else begin
            tern_in[d] = tern_ff[d];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int d = 0; d < MAX_DIMS; d++) begin
         if (cmd.start) tern_ff[d] <= 2'd0;
         else if (cmd.issue) tern_ff[d] <= tern_in[d];
      end
   end

   assign entry_wide = {{(OCT_SPAN - wcns_pkg::INDEX_WIDTH){1'b0}}, cmd.entry};

   for (genvar d = 0; d < MAX_DIMS; d++) begin : g_lane
      logic signed [wcns_pkg::GRID_WIDTH-1:0] grid_val;
      logic signed [wcns_pkg::DIFF_WIDTH-1:0] diff;
      logic [2:0]                             oct_digit;
      logic                                   active;
      logic [wcns_pkg::PROD_WIDTH-1:0]        prod;

      assign oct_digit = entry_wide[3 * (d % 4) +: 3];
      assign active    = (wcns_pkg::LEN_WIDTH'(d) < cmd.group_len);

      always_comb begin
         case (cmd.grid_mode)
            wcns_pkg::GRID_TERNARY: grid_val = wcns_pkg::ternary_level(tern_ff[d]);
            wcns_pkg::GRID_OCTAL:   grid_val = wcns_pkg::octal_level(oct_digit);
            default:                grid_val = wcns_pkg::table_level(cmd.entry[3:0]);
         endcase
      end

      assign diff = wcns_pkg::DIFF_WIDTH'(sample_store_ff[d])
                  - wcns_pkg::DIFF_WIDTH'(grid_val);
      assign prod = sq_ff[d] * weight_store_ff[d];

      // lanes beyond the group length contribute nothing
      always_ff @(posedge clock) begin
         if (!active) mag_ff[d] <= '0;
         else if (diff < 0) mag_ff[d] <= $unsigned(-diff);
         else mag_ff[d] <= $unsigned(diff);
         sq_ff[d]      <= mag_ff[d] * mag_ff[d];
         tree_ff[0][d] <= active ? SUM_WIDTH'(prod) : '0;
      end
   end

   for (genvar i = MAX_DIMS; i < LANES_P; i++) begin : g_pad_leaf
      always_ff @(posedge clock) begin
         tree_ff[0][i] <= '0;
      end
   end

   for (genvar k = 1; k <= LEVELS; k++) begin : g_level
      for (genvar i = 0; i < LANES_P; i++) begin : g_node
         if (i < (LANES_P >> k)) begin : g_sum
            always_ff @(posedge clock) begin
               tree_ff[k][i] <= tree_ff[k-1][2*i] + tree_ff[k-1][2*i+1];
            end
         end else begin : g_unused
            always_ff @(posedge clock) begin
               tree_ff[k][i] <= '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else v_ff <= {v_ff[LAST-1:0], cmd.issue};
   end

   always_ff @(posedge clock) begin
      idx_ff[0] <= cmd.entry;
      for (int s = 1; s <= LAST; s++) idx_ff[s] <= idx_ff[s-1];
   end

   // strict compare: equal distances keep the earlier (lower) index
   assign total = tree_ff[LEVELS][0];
   assign take  = v_ff[LAST] & (first_ff | (total < best_sum_ff));

   always_ff @(posedge clock) begin
      if (reset) first_ff <= 1'b1;
      else if (cmd.start) first_ff <= 1'b1;
      else if (take) first_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (take) begin
         best_sum_ff <= total;
         best_idx_ff <= idx_ff[LAST];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_ff.codeword_index <= cmd.rsp_err ? '0 : best_idx_ff;
         rsp_ff.group_error    <= cmd.rsp_err;
      end
   end

   assign rsp_payload     = rsp_ff;
   assign stat.pipe_empty = ~|v_ff;

endmodule

`default_nettype wire

// ----- rtl/weighted_codebook_nearest_search_top.sv -----
// ------------------------------------------------------------------------------------------
// weighted_codebook_nearest_search_top - weighted nearest codeword search
// Groups samples by grid mode and returns the index of the closest codeword.
// ------------------------------------------------------------------------------------------
//  channel  | ports                       | moves
//  ---------+-----------------------------+---------------------------------------
//  req      | req_valid/ready/payload     | one sample and weight per request
//  rsp      | rsp_valid/ready/payload     | codeword index or partial-group error
//  csr      | csr_valid/ready/wdata       | grid mode write
//
// A request that does not finish a group is only stored; a finishing one starts a search
// over GRID_ENTRIES codewords (grid modes 0, 1) or 16, and one codeword enters the lane
// pipeline per cycle. A partial-group error skips the search.
// Reset is synchronous; no clearing pass. The result register lets the next group fill
// while a result waits; a search only stalls at its end if the previous result is unread.
// ------------------------------------------------------------------------------------------
`default_nettype none

module weighted_codebook_nearest_search_top #(
   parameter int unsigned MAX_DIMS     = 8,
   parameter int unsigned GRID_ENTRIES = 256
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output      logic                            req_ready,
   input  wire wcns_pkg::req_payload_type       req_payload,
   output      logic                            rsp_valid,
   input  wire logic                            rsp_ready,
   output      wcns_pkg::rsp_payload_type       rsp_payload,
   input  wire logic                            csr_valid,
   output      logic                            csr_ready,
   input  wire logic [wcns_pkg::MODE_WIDTH-1:0] csr_wdata
);

   wcns_pkg::cmd_type  cmd;
   wcns_pkg::stat_type stat;

   wcns_ctrl #(
      .MAX_DIMS     (MAX_DIMS),
      .GRID_ENTRIES (GRID_ENTRIES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_end   (req_payload.end_of_block),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   wcns_dp #(
      .MAX_DIMS (MAX_DIMS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_payload (req_payload),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

// ----- rtl/wcns_checker.sv -----
// ------------------------------------------------------------------------------------------
// wcns_checker - port-level checks
// Result channel behaviour as seen on the top-level ports, bound to the top level.
// ------------------------------------------------------------------------------------------
`default_nettype none

module wcns_checker (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      req_ready,
   input wire logic                      rsp_valid,
   input wire logic                      rsp_ready,
   input wire wcns_pkg::rsp_payload_type rsp_payload
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed while stalled");

   // an error result carries index zero
   a_err_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.group_error |-> rsp_payload.codeword_index == '0)
      else $error("error result with non-zero index");

   // a fresh result only appears while requests are held off
   a_rsp_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result raised while taking requests");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind weighted_codebook_nearest_search_top wcns_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

`default_nettype wire

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ------------------------------------------------------------------------------------------
// testbench - weighted nearest codeword search
// Streams samples and weights through every grid mode with random bursts and back-pressure.
// A scoreboard predicts each group's nearest index or partial-group error and checks the
// results in order.
// ------------------------------------------------------------------------------------------

module testbench;

   localparam int unsigned MAX_DIMS_TB     = 8;
   localparam int unsigned GRID_ENTRIES_TB = 256;
   localparam logic [wcns_pkg::MODE_WIDTH-1:0] GRID_SPARE = 2'd3;
   localparam int unsigned DRAIN_SLACK  = 280;
   localparam int unsigned LONG_HOLD    = 2000;
   localparam int unsigned PHASE_ITEMS  = 143;
   localparam int unsigned PHASE_COUNT  = 10;
   localparam int unsigned CYCLE_LIMIT  = 2000000;

   class nearest_scoreboard;
      logic [wcns_pkg::MODE_WIDTH-1:0]          grid_mode;
      logic signed [wcns_pkg::VALUE_WIDTH-1:0]  held_samples [MAX_DIMS_TB];
      logic [wcns_pkg::WEIGHT_WIDTH-1:0]        held_weights [MAX_DIMS_TB];
      int unsigned                              fill;
      wcns_pkg::rsp_payload_type                expected_results [$];
      int unsigned                              mismatches;
      int unsigned                              requests_seen;
      int unsigned                              index_results;
      int unsigned                              error_results;

      function new();
         grid_mode = wcns_pkg::GRID_TERNARY;
         fill = 0;
         mismatches = 0;
         requests_seen = 0;
         index_results = 0;
         error_results = 0;
      endfunction

      function int unsigned pending();
         return expected_results.size();
      endfunction

      function int unsigned group_length();
         int unsigned n;
         case (grid_mode)
            wcns_pkg::GRID_TERNARY: n = 8;
            wcns_pkg::GRID_OCTAL:   n = 4;
            default:                n = 1;
         endcase
         return (n > MAX_DIMS_TB) ? MAX_DIMS_TB : n;
      endfunction

      function int table_step(int unsigned idx);
         int v;
         case (idx)
            0:       v = -127;
            1:       v = -104;
            2:       v = -83;
            3:       v = -65;
            4:       v = -49;
            5:       v = -35;
            6:       v = -22;
            7:       v = -10;
            8:       v = 1;
            9:       v = 13;
            10:      v = 25;
            11:      v = 38;
            12:      v = 53;
            13:      v = 69;
            14:      v = 89;
            default: v = 113;
         endcase
         return v;
      endfunction

      function int grid_level(int unsigned e, int unsigned d);
         int unsigned v;
         int lv;
         v = e;
         case (grid_mode)
            wcns_pkg::GRID_TERNARY: begin
               for (int unsigned i = 0; i < d; i++) v = v / 3;
               lv = (int'(v % 3) - 1) * 128;
            end
            wcns_pkg::GRID_OCTAL: begin
               // -1 + 2i/7 in Q8.8, rounded to nearest
               v = (e >> (3 * (d % 4))) % 8;
               lv = -256 + int'((512 * v + 3) / 7);
            end
            default: lv = table_step(e % 16) * 256;
         endcase
         return lv;
      endfunction

      function logic [wcns_pkg::INDEX_WIDTH-1:0] nearest_index(int unsigned n);
         int unsigned entries;
         logic [63:0] best_cost;
         logic [63:0] cost;
         logic [wcns_pkg::INDEX_WIDTH-1:0] best;
         longint diff;
         longint unsigned w;
         if (grid_mode == wcns_pkg::GRID_TERNARY || grid_mode == wcns_pkg::GRID_OCTAL)
            entries = (GRID_ENTRIES_TB > 256) ? 256 : GRID_ENTRIES_TB;
         else
            entries = wcns_pkg::TABLE_ENTRIES;
         best = '0;
         best_cost = '1;
         for (int unsigned e = 0; e < entries; e++) begin
            cost = '0;
            for (int unsigned d = 0; d < n; d++) begin
               diff = longint'(held_samples[d]) - longint'(grid_level(e, d));
               w = (held_weights[d] == '0) ? longint'(wcns_pkg::WEIGHT_ONE)
                                           : longint'(held_weights[d]);
               cost += 64'(diff * diff) * w;
            end
            // strict compare keeps the lowest index on a tie
            if (e == 0 || cost < best_cost) begin
               best_cost = cost;
               best = wcns_pkg::INDEX_WIDTH'(e);
            end
         end
         return best;
      endfunction

      function void note_mode(logic [wcns_pkg::MODE_WIDTH-1:0] m);
         grid_mode = m;
         fill = 0;
      endfunction

      function void note_request(wcns_pkg::req_payload_type p);
         int unsigned n;
         int unsigned pos;
         wcns_pkg::rsp_payload_type r;
         n = group_length();
         pos = (fill >= n) ? 0 : fill;
         requests_seen++;
         held_samples[pos] = p.sample_value;
         held_weights[pos] = p.importance_weight;
         pos++;
         if (pos >= n) begin
            fill = 0;
            r.codeword_index = nearest_index(n);
            r.group_error = 1'b0;
            expected_results.push_back(r);
         end else if (p.end_of_block) begin
            fill = 0;
            r.codeword_index = '0;
            r.group_error = 1'b1;
            expected_results.push_back(r);
         end else begin
            fill = pos;
         end
      endfunction

      function void check_result(wcns_pkg::rsp_payload_type actual);
         wcns_pkg::rsp_payload_type want;
         if (expected_results.size() == 0) begin
            mismatches++;
            $display("%0t: result with nothing expected: expected none, actual index %0d err %0b",
                     $time, actual.codeword_index, actual.group_error);
            return;
         end
         want = expected_results.pop_front();
         if (want.group_error) error_results++;
         else index_results++;
         if (actual.group_error !== want.group_error) begin
            mismatches++;
            $display("%0t: group_error mismatch: expected %0b, actual %0b",
                     $time, want.group_error, actual.group_error);
         end
         if (actual.codeword_index !== want.codeword_index) begin
            mismatches++;
            $display("%0t: codeword_index mismatch: expected %0d, actual %0d",
                     $time, want.codeword_index, actual.codeword_index);
         end
      endfunction
   endclass

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   wcns_pkg::req_payload_type       req_payload = '0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   wcns_pkg::rsp_payload_type       rsp_payload;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [wcns_pkg::MODE_WIDTH-1:0] csr_wdata = wcns_pkg::GRID_TERNARY;

   nearest_scoreboard sb = new();

   int unsigned cycle_count = 0;
   int unsigned burst_left = 0;
   int unsigned hold_requests = 0;
   int unsigned hold_served = 0;
   int unsigned hold_left = 0;
   int unsigned pattern_left = 0;
   int unsigned pattern_kind = 0;

   weighted_codebook_nearest_search_top #(
      .MAX_DIMS     (MAX_DIMS_TB),
      .GRID_ENTRIES (GRID_ENTRIES_TB)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_wdata   (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time, sb.pending());
         $display("weighted_codebook_nearest_search_top test failed");
         $finish;
      end
   end

   // handshake monitor feeding the scoreboard
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) sb.note_mode(csr_wdata);
         if (req_valid && req_ready) sb.note_request(req_payload);
         if (rsp_valid && rsp_ready) sb.check_result(rsp_payload);
      end
   end

   // result side: long hold on demand, otherwise a shifting stall pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_served != hold_requests) begin
         hold_served <= hold_requests;
         hold_left <= LONG_HOLD;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         if (pattern_left == 0) begin
            pattern_kind <= $urandom_range(0, 3);
            pattern_left <= $urandom_range(16, 300);
         end else begin
            pattern_left <= pattern_left - 1;
         end
         case (pattern_kind)
            0:       rsp_ready <= 1'b1;
            1:       rsp_ready <= 1'($urandom_range(0, 1));
            2:       rsp_ready <= ($urandom_range(0, 7) == 0);
            default: rsp_ready <= ((pattern_left % 16) < 5);
         endcase
      end
   end

   function automatic wcns_pkg::req_payload_type make_request(int sample, int weight,
                                                              logic last);
      wcns_pkg::req_payload_type p;
      p.sample_value = wcns_pkg::VALUE_WIDTH'(sample);
      p.importance_weight = wcns_pkg::WEIGHT_WIDTH'(weight);
      p.end_of_block = last;
      return p;
   endfunction

   function automatic wcns_pkg::req_payload_type random_request(logic last);
      wcns_pkg::req_payload_type p;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 35)
         p.sample_value = wcns_pkg::VALUE_WIDTH'($urandom_range(0, 65535));
      else if (pick < 80)
         p.sample_value = wcns_pkg::VALUE_WIDTH'(int'($urandom_range(0, 1024)) - 512);
      else if (pick < 90)
         p.sample_value = wcns_pkg::VALUE_WIDTH'((int'($urandom_range(0, 16)) - 8) * 64);
      else
         p.sample_value = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      pick = $urandom_range(0, 99);
      if (pick < 15)
         p.importance_weight = '0;
      else if (pick < 40)
         p.importance_weight = wcns_pkg::WEIGHT_WIDTH'($urandom_range(1, 600));
      else
         p.importance_weight = wcns_pkg::WEIGHT_WIDTH'($urandom_range(0, 65535));
      p.end_of_block = last;
      return p;
   endfunction

   // called at a rising edge; returns at the edge where the request is taken
   task automatic push_request(input wcns_pkg::req_payload_type p);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 48);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_payload <= p;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_SLACK) @(posedge clock);
   endtask

   task automatic write_mode(input logic [wcns_pkg::MODE_WIDTH-1:0] m);
      csr_valid <= 1'b1;
      csr_wdata <= m;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [wcns_pkg::MODE_WIDTH-1:0] mode_for_phase(int unsigned i);
      logic [wcns_pkg::MODE_WIDTH-1:0] m;
      case (i % 5)
         0:       m = wcns_pkg::GRID_OCTAL;
         1:       m = wcns_pkg::GRID_TERNARY;
         2:       m = wcns_pkg::GRID_TABLE;
         3:       m = (i < 5) ? GRID_SPARE : wcns_pkg::GRID_OCTAL;
         default: m = wcns_pkg::GRID_TERNARY;
      endcase
      return m;
   endfunction

   task automatic run_phase(input logic [wcns_pkg::MODE_WIDTH-1:0] m,
                            input int unsigned count,
                            input bit squeeze, input bit pause_midway);
      int unsigned sent;
      int unsigned n;
      int unsigned len;
      int unsigned kind;
      bit paused;
      sent = 0;
      paused = 1'b0;
      n = (m == wcns_pkg::GRID_TERNARY) ? 8 : (m == wcns_pkg::GRID_OCTAL) ? 4 : 1;
      wait_drained();
      write_mode(m);
      if (squeeze) hold_requests <= hold_requests + 1;
      while (sent < count) begin
         if (pause_midway && !paused && sent >= count / 2) begin
            paused = 1'b1;
            wait_drained();
         end
         kind = $urandom_range(0, 99);
         if (kind < 84) begin
            // complete group, sometimes closing the block on its last element
            for (int unsigned k = 0; k < n; k++)
               push_request(random_request((k == n - 1) && ($urandom_range(0, 4) == 0)));
            sent += n;
         end else if (kind < 94 && n > 1) begin
            // block ends early: partial group
            len = $urandom_range(1, n - 1);
            for (int unsigned k = 0; k < len; k++)
               push_request(random_request(k == len - 1));
            sent += len;
         end else begin
            len = $urandom_range(1, n + 2);
            for (int unsigned k = 0; k < len; k++)
               push_request(random_request($urandom_range(0, 3) == 0));
            sent += len;
         end
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ternary grid: extremes, midpoint ties, zero and full weights
      write_mode(wcns_pkg::GRID_TERNARY);
      push_request(make_request(32767, 0, 1'b0));
      push_request(make_request(-32768, 65535, 1'b0));
      push_request(make_request(64, 1, 1'b0));
      push_request(make_request(-64, 256, 1'b0));
      push_request(make_request(0, 0, 1'b0));
      push_request(make_request(128, 65535, 1'b0));
      push_request(make_request(-128, 32768, 1'b0));
      push_request(make_request(1, 7, 1'b1));
      // block ends inside a group
      push_request(make_request(100, 300, 1'b0));
      push_request(make_request(-100, 0, 1'b0));
      push_request(make_request(5, 5, 1'b1));

      // octal grid: zero input ties between the two inner levels
      wait_drained();
      write_mode(wcns_pkg::GRID_OCTAL);
      push_request(make_request(0, 0, 1'b0));
      push_request(make_request(0, 0, 1'b0));
      push_request(make_request(-32768, 65535, 1'b0));
      push_request(make_request(32767, 65535, 1'b0));
      // partial group left behind, then dropped by the mode change
      push_request(make_request(256, 256, 1'b0));
      push_request(make_request(-256, 256, 1'b0));

      wait_drained();
      write_mode(wcns_pkg::GRID_TABLE);
      push_request(make_request(-29568, 256, 1'b0));
      push_request(make_request(32767, 65535, 1'b1));
      push_request(make_request(-32768, 1, 1'b0));
      push_request(make_request(0, 0, 1'b0));

      // unused mode code acts as the table
      wait_drained();
      write_mode(GRID_SPARE);
      push_request(make_request(28928, 0, 1'b0));
      push_request(make_request(-1, 65535, 1'b1));

      for (int unsigned i = 0; i < PHASE_COUNT; i++)
         run_phase(mode_for_phase(i), PHASE_ITEMS, i == 2, i == 4);

      wait_drained();
      $display("Run covered %0d requests over grid modes 0-3: %0d indices, %0d partial groups.",
               sb.requests_seen, sb.index_results, sb.error_results);
      $display("Included a %0d-cycle result stall and drain pauses; %0d mismatches.",
               LONG_HOLD, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("weighted_codebook_nearest_search_top test passed");
      end else begin
         $display("weighted_codebook_nearest_search_top test failed");
      end
      $finish;
   end

endmodule
